FILE: design/spa_pkg.sv
package spa_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_TERMS_DEF = 32;
    localparam int EXP_BITS_DEF  = 16;

    // Fixed field widths
    localparam int KIND_W  = 2;
    localparam int COEFF_W = 32;
    localparam int SUM_W   = 33;
    localparam int EXP_W   = 16;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_SECOND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN         = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MERGE = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    // Which head terms the merge step consumes
    typedef struct packed {
        logic take_first;
        logic take_second;
    } pick_t;

endpackage

FILE: design/sparse_polynomial_add_unit.sv
// Channel   Direction  Handshake          Beat contents
// s_        in         s_valid / s_ready  s_kind, s_coeff_in, s_exponent_in
// m_        out        m_valid / m_ready  m_sum_coeff, m_sum_exponent,
//                                         m_last_term, m_dropped_terms
//
// A load beat writes its term to its store at the edge that accepts it. A run
// beat with both stores empty leaves the block idle. A run beat takes a merge
// step, then an output hold, for each result term, and the hold lasts while
// the sink stalls m_ready; the registered read of each term store sets that
// pace. s_ready is low for the whole run.
// Reset (aresetn low, synchronous) empties both stores and clears the flag.
module sparse_polynomial_add_unit #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF,
    parameter int EXP_BITS  = spa_pkg::EXP_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [spa_pkg::KIND_W-1:0]         s_kind,
    input  logic signed [spa_pkg::COEFF_W-1:0] s_coeff_in,
    input  logic [spa_pkg::EXP_W-1:0]          s_exponent_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [spa_pkg::SUM_W-1:0]   m_sum_coeff,
    output logic [spa_pkg::EXP_W-1:0]          m_sum_exponent,
    output logic                               m_last_term,
    output logic                               m_dropped_terms
);

    // Stored exponent width: the port carries 16 bits, EXP_BITS may keep fewer
    localparam int EW = (EXP_BITS < spa_pkg::EXP_W) ? EXP_BITS : spa_pkg::EXP_W;
    // Store address width and count width (count reaches MAX_TERMS itself)
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);

    spa_pkg::state_t state_reg, state_next;

    logic [CW-1:0] first_cnt_reg, first_cnt_next;
    logic [CW-1:0] second_cnt_reg, second_cnt_next;
    logic [CW-1:0] first_idx_reg, first_idx_next;
    logic [CW-1:0] second_idx_reg, second_idx_next;
    logic          overflow_reg, overflow_next;

    logic signed [spa_pkg::SUM_W-1:0] sum_coeff_reg, sum_coeff_next;
    logic [EW-1:0]                    sum_exp_reg, sum_exp_next;
    logic                             last_reg, last_next;
    logic                             dropped_reg, dropped_next;

    logic first_we;
    logic second_we;

    logic signed [spa_pkg::COEFF_W-1:0] first_rd_coeff;
    logic [EW-1:0]                      first_rd_exp;
    logic signed [spa_pkg::COEFF_W-1:0] second_rd_coeff;
    logic [EW-1:0]                      second_rd_exp;

    logic                             first_head_valid;
    logic                             second_head_valid;
    spa_pkg::pick_t                   pick;
    logic signed [spa_pkg::SUM_W-1:0] merge_coeff;
    logic [EW-1:0]                    merge_exp;
    logic [CW-1:0]                    first_idx_adv;
    logic [CW-1:0]                    second_idx_adv;

    // Term stores; read address follows the next head index so the head
    // term is ready in the cycle after an index change
    spa_term_store #(
        .DEPTH (MAX_TERMS),
        .AW    (AW),
        .EW    (EW)
    ) u_first_store (
        .aclk     (aclk),
        .wr_en    (first_we),
        .wr_addr  (first_cnt_reg[AW-1:0]),
        .wr_coeff (s_coeff_in),
        .wr_exp   (s_exponent_in[EW-1:0]),
        .rd_addr  (first_idx_next[AW-1:0]),
        .rd_coeff (first_rd_coeff),
        .rd_exp   (first_rd_exp)
    );

    spa_term_store #(
        .DEPTH (MAX_TERMS),
        .AW    (AW),
        .EW    (EW)
    ) u_second_store (
        .aclk     (aclk),
        .wr_en    (second_we),
        .wr_addr  (second_cnt_reg[AW-1:0]),
        .wr_coeff (s_coeff_in),
        .wr_exp   (s_exponent_in[EW-1:0]),
        .rd_addr  (second_idx_next[AW-1:0]),
        .rd_coeff (second_rd_coeff),
        .rd_exp   (second_rd_exp)
    );

    assign first_head_valid  = first_idx_reg < first_cnt_reg;
    assign second_head_valid = second_idx_reg < second_cnt_reg;

    // Shared compare and add over the two head terms
    spa_merge_unit #(
        .EW (EW)
    ) u_merge (
        .first_valid  (first_head_valid),
        .first_coeff  (first_rd_coeff),
        .first_exp    (first_rd_exp),
        .second_valid (second_head_valid),
        .second_coeff (second_rd_coeff),
        .second_exp   (second_rd_exp),
        .pick         (pick),
        .sum_coeff    (merge_coeff),
        .sum_exp      (merge_exp)
    );

    assign first_idx_adv  = first_idx_reg + CW'(pick.take_first);
    assign second_idx_adv = second_idx_reg + CW'(pick.take_second);

    always_comb begin
        state_next      = state_reg;
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        first_idx_next  = first_idx_reg;
        second_idx_next = second_idx_reg;
        overflow_next   = overflow_reg;
        sum_coeff_next  = sum_coeff_reg;
        sum_exp_next    = sum_exp_reg;
        last_next       = last_reg;
        dropped_next    = dropped_reg;
        first_we        = 1'b0;
        second_we       = 1'b0;

        case (state_reg)
            spa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_kind)
                        spa_pkg::KIND_LOAD_FIRST: begin
                            // Append, or drop and flag when full
                            if (first_cnt_reg < CW'(MAX_TERMS)) begin
                                first_we       = 1'b1;
                                first_cnt_next = first_cnt_reg + CW'(1);
                            end else begin
                                overflow_next = 1'b1;
                            end
                        end
                        spa_pkg::KIND_LOAD_SECOND: begin
                            if (second_cnt_reg < CW'(MAX_TERMS)) begin
                                second_we       = 1'b1;
                                second_cnt_next = second_cnt_reg + CW'(1);
                            end else begin
                                overflow_next = 1'b1;
                            end
                        end
                        spa_pkg::KIND_RUN: begin
                            // Both stores empty: nothing to emit, flag is clear
                            first_idx_next  = '0;
                            second_idx_next = '0;
                            if ((first_cnt_reg != '0) || (second_cnt_reg != '0)) begin
                                state_next = spa_pkg::ST_MERGE;
                            end
                        end
                        default: begin
                            // Unused kind: ignore the beat
                        end
                    endcase
                end
            end
            spa_pkg::ST_MERGE: begin
                // Capture one merged term and advance the consumed heads
                sum_coeff_next  = merge_coeff;
                sum_exp_next    = merge_exp;
                dropped_next    = overflow_reg;
                last_next       = (first_idx_adv >= first_cnt_reg) &&
                                  (second_idx_adv >= second_cnt_reg);
                first_idx_next  = first_idx_adv;
                second_idx_next = second_idx_adv;
                state_next      = spa_pkg::ST_EMIT;
            end
            spa_pkg::ST_EMIT: begin
                // Hold the term until the sink takes it
                if (m_ready) begin
                    if (last_reg) begin
                        first_cnt_next  = '0;
                        second_cnt_next = '0;
                        overflow_next   = 1'b0;
                        state_next      = spa_pkg::ST_IDLE;
                    end else begin
                        state_next = spa_pkg::ST_MERGE;
                    end
                end
            end
            default: begin
                state_next = spa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= spa_pkg::ST_IDLE;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            first_idx_reg  <= '0;
            second_idx_reg <= '0;
            overflow_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            first_idx_reg  <= first_idx_next;
            second_idx_reg <= second_idx_next;
            overflow_reg   <= overflow_next;
        end
    end

    // Output beat register: payload only, no reset
    always_ff @(posedge aclk) begin
        sum_coeff_reg <= sum_coeff_next;
        sum_exp_reg   <= sum_exp_next;
        last_reg      <= last_next;
        dropped_reg   <= dropped_next;
    end

    assign s_ready         = (state_reg == spa_pkg::ST_IDLE);
    assign m_valid         = (state_reg == spa_pkg::ST_EMIT);
    assign m_sum_coeff     = sum_coeff_reg;
    assign m_sum_exponent  = spa_pkg::EXP_W'(sum_exp_reg);
    assign m_last_term     = last_reg;
    assign m_dropped_terms = dropped_reg;

endmodule

FILE: design/spa_term_store.sv
module spa_term_store #(
    parameter int DEPTH = spa_pkg::MAX_TERMS_DEF,
    parameter int AW    = 5,
    parameter int EW    = 16
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [AW-1:0]                    wr_addr,
    input  logic signed [spa_pkg::COEFF_W-1:0] wr_coeff,
    input  logic [EW-1:0]                    wr_exp,
    input  logic [AW-1:0]                    rd_addr,
    output logic signed [spa_pkg::COEFF_W-1:0] rd_coeff,
    output logic [EW-1:0]                    rd_exp
);

    logic [spa_pkg::COEFF_W+EW-1:0] mem [DEPTH];
    logic [spa_pkg::COEFF_W+EW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_coeff, wr_exp};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_coeff = rd_data_reg[spa_pkg::COEFF_W+EW-1:EW];
    assign rd_exp   = rd_data_reg[EW-1:0];

endmodule

FILE: design/spa_merge_unit.sv
module spa_merge_unit #(
    parameter int EW = 16
) (
    input  logic                               first_valid,
    input  logic signed [spa_pkg::COEFF_W-1:0] first_coeff,
    input  logic [EW-1:0]                      first_exp,
    input  logic                               second_valid,
    input  logic signed [spa_pkg::COEFF_W-1:0] second_coeff,
    input  logic [EW-1:0]                      second_exp,
    output spa_pkg::pick_t                     pick,
    output logic signed [spa_pkg::SUM_W-1:0]   sum_coeff,
    output logic [EW-1:0]                      sum_exp
);

    logic signed [spa_pkg::SUM_W-1:0] addend_first;
    logic signed [spa_pkg::SUM_W-1:0] addend_second;

    always_comb begin
        pick = '0;
        if (first_valid && second_valid) begin
            if (first_exp > second_exp) begin
                pick.take_first = 1'b1;
            end else if (first_exp < second_exp) begin
                pick.take_second = 1'b1;
            end else begin
                pick.take_first  = 1'b1;
                pick.take_second = 1'b1;
            end
        end else if (first_valid) begin
            pick.take_first = 1'b1;
        end else begin
            pick.take_second = 1'b1;
        end
    end

    // Sign-extend and gate each head, then one shared adder
    assign addend_first  = pick.take_first  ? spa_pkg::SUM_W'(first_coeff)  : '0;
    assign addend_second = pick.take_second ? spa_pkg::SUM_W'(second_coeff) : '0;
    assign sum_coeff     = addend_first + addend_second;
    assign sum_exp       = pick.take_first ? first_exp : second_exp;

endmodule

FILE: tb/sparse_polynomial_add_unit_test.sv
`timescale 1ns / 100ps

module sparse_polynomial_add_unit_test;

    // Kind 3 has no name in the package: the block must swallow it silently
    localparam logic [spa_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int unsigned CYCLE_LIMIT     = 500000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned ITEMS_PER_PHASE = 84;

    // One merged term as it should leave the m_ channel
    typedef struct {
        logic signed [spa_pkg::SUM_W-1:0] coeff;
        logic [spa_pkg::EXP_W-1:0]        exponent;
        logic                             last;
        logic                             dropped;
    } merged_term_t;

    // Scoreboard: keeps its own copy of both term stores and predicts the
    // merged terms of every run beat, then checks results against them.
    class term_merge_scoreboard;
        logic [spa_pkg::COEFF_W-1:0] first_coeff [spa_pkg::MAX_TERMS_DEF];
        logic [spa_pkg::EXP_W-1:0]   first_exp   [spa_pkg::MAX_TERMS_DEF];
        logic [spa_pkg::COEFF_W-1:0] second_coeff[spa_pkg::MAX_TERMS_DEF];
        logic [spa_pkg::EXP_W-1:0]   second_exp  [spa_pkg::MAX_TERMS_DEF];
        int unsigned                 first_len;
        int unsigned                 second_len;
        logic                        terms_dropped;
        merged_term_t                merged_terms[$];
        int unsigned                 mismatches;

        function new();
            first_len     = 0;
            second_len    = 0;
            terms_dropped = 1'b0;
            mismatches    = 0;
        endfunction

        function automatic logic signed [spa_pkg::SUM_W-1:0] widen(
            logic [spa_pkg::COEFF_W-1:0] c);
            return {c[spa_pkg::COEFF_W-1], c};
        endfunction

        function void push_term(logic signed [spa_pkg::SUM_W-1:0] c,
                                logic [spa_pkg::EXP_W-1:0] e);
            merged_term_t t;
            t.coeff    = c;
            t.exponent = e;
            t.last     = 1'b0;
            t.dropped  = terms_dropped;
            merged_terms.push_back(t);
        endfunction

        // Walk both stores head to head, larger exponent first
        function void merge_stores();
            int unsigned  i;
            int unsigned  j;
            int unsigned  start_size;
            merged_term_t tail;
            i          = 0;
            j          = 0;
            start_size = merged_terms.size();
            while (i < first_len && j < second_len) begin
                if (first_exp[i] > second_exp[j]) begin
                    push_term(widen(first_coeff[i]), first_exp[i]);
                    i++;
                end else if (first_exp[i] < second_exp[j]) begin
                    push_term(widen(second_coeff[j]), second_exp[j]);
                    j++;
                end else begin
                    push_term(widen(first_coeff[i]) + widen(second_coeff[j]), first_exp[i]);
                    i++;
                    j++;
                end
            end
            while (i < first_len) begin
                push_term(widen(first_coeff[i]), first_exp[i]);
                i++;
            end
            while (j < second_len) begin
                push_term(widen(second_coeff[j]), second_exp[j]);
                j++;
            end
            // Mark the closing term of this run, if the run gave any
            if (merged_terms.size() > start_size) begin
                tail      = merged_terms.pop_back();
                tail.last = 1'b1;
                merged_terms.push_back(tail);
            end
            first_len     = 0;
            second_len    = 0;
            terms_dropped = 1'b0;
        endfunction

        function void note_input(logic [spa_pkg::KIND_W-1:0] kind,
                                 logic [spa_pkg::COEFF_W-1:0] c,
                                 logic [spa_pkg::EXP_W-1:0] e);
            case (kind)
                spa_pkg::KIND_LOAD_FIRST: begin
                    if (first_len < spa_pkg::MAX_TERMS_DEF) begin
                        first_coeff[first_len] = c;
                        first_exp[first_len]   = e;
                        first_len++;
                    end else begin
                        terms_dropped = 1'b1;
                    end
                end
                spa_pkg::KIND_LOAD_SECOND: begin
                    if (second_len < spa_pkg::MAX_TERMS_DEF) begin
                        second_coeff[second_len] = c;
                        second_exp[second_len]   = e;
                        second_len++;
                    end else begin
                        terms_dropped = 1'b1;
                    end
                end
                spa_pkg::KIND_RUN: begin
                    merge_stores();
                end
                default: begin
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic signed [spa_pkg::SUM_W-1:0] c, logic [spa_pkg::EXP_W-1:0] e,
                          logic last, logic dropped);
            merged_term_t want;
            if (merged_terms.size() == 0) begin
                report_mismatch($sformatf("unexpected term coeff %0d exponent %0d", c, e));
            end else begin
                want = merged_terms.pop_front();
                if (c !== want.coeff)
                    report_mismatch($sformatf("sum_coeff %0d, want %0d", c, want.coeff));
                if (e !== want.exponent)
                    report_mismatch($sformatf("sum_exponent %0d, want %0d", e, want.exponent));
                if (last !== want.last)
                    report_mismatch($sformatf("last_term %b, want %b", last, want.last));
                if (dropped !== want.dropped)
                    report_mismatch($sformatf("dropped_terms %b, want %b", dropped,
                                              want.dropped));
            end
        endtask

        function int unsigned pending();
            return merged_terms.size();
        endfunction
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic [spa_pkg::KIND_W-1:0]         s_kind;
    logic signed [spa_pkg::COEFF_W-1:0] s_coeff_in;
    logic [spa_pkg::EXP_W-1:0]          s_exponent_in;
    logic                               m_valid;
    logic                               m_ready  = 1'b0;
    logic signed [spa_pkg::SUM_W-1:0]   m_sum_coeff;
    logic [spa_pkg::EXP_W-1:0]          m_sum_exponent;
    logic                               m_last_term;
    logic                               m_dropped_terms;

    term_merge_scoreboard sb;
    int unsigned          cycle_count   = 0;
    int unsigned          items_sent    = 0;
    int unsigned          send_idle_pct = 0;
    int unsigned          stall_pct     = 0;
    logic                 hold_off      = 1'b0;

    sparse_polynomial_add_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_coeff_in      (s_coeff_in),
        .s_exponent_in   (s_exponent_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sum_coeff     (m_sum_coeff),
        .m_sum_exponent  (m_sum_exponent),
        .m_last_term     (m_last_term),
        .m_dropped_terms (m_dropped_terms)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sink: stall at random, or hold off completely during the pressure stretch
    always @(posedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // Monitor: sample both channels on the edge, before any update lands.
    // Check the result first so an older run is always matched before
    // a newly accepted beat can add to the queue.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_sum_coeff, m_sum_exponent, m_last_term, m_dropped_terms);
            if (s_valid && s_ready)
                sb.note_input(s_kind, s_coeff_in, s_exponent_in);
        end
    end

    // Watchdog: stop a run that hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Coefficients lean on the extremes and zero so sums hit both ends of 33 bits
    function automatic logic [spa_pkg::COEFF_W-1:0] pick_coeff();
        logic [spa_pkg::COEFF_W-1:0] v;
        case ($urandom_range(7))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            2:       v = '0;
            3:       v = 32'hffff_ffff;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Offer one beat; idle first at the current rate, then hold until accepted.
    // Each path gives s_valid at most one update per time step.
    task automatic send_item(input logic [spa_pkg::KIND_W-1:0] kind,
                             input logic [spa_pkg::COEFF_W-1:0] c,
                             input logic [spa_pkg::EXP_W-1:0] e);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_coeff_in    <= c;
        s_exponent_in <= e;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic send_run();
        send_item(spa_pkg::KIND_RUN, $urandom(), 16'($urandom()));
    endtask

    // Load a pair of polynomials drawn from one pool of exponents. Each pool
    // exponent lands in the first store, the second, or both, so the merge
    // sees strict wins either way and ties, some of which cancel.
    task automatic send_term_set(input int unsigned pool_len, input bit in_order,
                                 input bit into_both);
        logic [spa_pkg::EXP_W-1:0]   e;
        logic [spa_pkg::COEFF_W-1:0] c;
        int unsigned                 place;
        int unsigned                 step;
        e = ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom_range(65535, 30000));
        for (int unsigned k = 0; k < pool_len; k++) begin
            if (!in_order)
                e = 16'($urandom());
            c     = pick_coeff();
            place = into_both ? 2 : $urandom_range(2);
            if (place != 1)
                send_item(spa_pkg::KIND_LOAD_FIRST, c, e);
            if (place != 0)
                send_item(spa_pkg::KIND_LOAD_SECOND,
                          (place == 2 && $urandom_range(3) == 0) ? -c : pick_coeff(), e);
            step = $urandom_range(1500);
            e    = (e > step) ? e - 16'(step) : '0;
        end
    endtask

    // One random action: mostly well-formed polynomial pairs, then noise
    task automatic random_action();
        int unsigned roll;
        int unsigned pool_len;
        roll = $urandom_range(99);
        case ($urandom_range(19))
            0:       pool_len = $urandom_range(40, 33);
            1, 2:    pool_len = $urandom_range(32, 11);
            default: pool_len = $urandom_range(10, 1);
        endcase
        if (roll < 75) begin
            send_term_set(pool_len, 1'b1, 1'b0);
            send_run();
        end else if (roll < 85) begin
            send_term_set(pool_len, 1'b0, 1'b0);
            send_run();
        end else if (roll < 92) begin
            send_item(KIND_UNUSED, $urandom(), 16'($urandom()));
        end else if (roll < 96) begin
            send_run();
        end else begin
            // Partial load left for whatever run comes next
            send_term_set($urandom_range(4, 1), 1'b1, 1'b0);
        end
    endtask

    initial begin
        int unsigned phase_send [4];
        int unsigned phase_stall[4];
        int unsigned target;
        phase_send  = '{0, 85, 0, 6};
        phase_stall = '{0, 0, 85, 6};
        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_kind        = spa_pkg::KIND_LOAD_FIRST;
        s_coeff_in    = '0;
        s_exponent_in = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: run on empty stores, ignored kind, extreme fields
        send_run();
        send_item(KIND_UNUSED, 32'hffff_ffff, 16'hffff);
        send_item(spa_pkg::KIND_LOAD_FIRST, 32'h7fff_ffff, 16'hffff);
        send_item(spa_pkg::KIND_LOAD_FIRST, 32'h8000_0000, 16'h0000);
        send_item(spa_pkg::KIND_LOAD_SECOND, 32'h7fff_ffff, 16'hffff);
        send_item(spa_pkg::KIND_LOAD_SECOND, 32'h8000_0000, 16'h0000);
        send_run();
        // Tie whose coefficients cancel, then a tail from the second store
        send_item(spa_pkg::KIND_LOAD_FIRST, 32'd5, 16'd100);
        send_item(spa_pkg::KIND_LOAD_SECOND, -32'sd5, 16'd100);
        send_item(spa_pkg::KIND_LOAD_SECOND, 32'd7, 16'd50);
        send_run();
        // Unsorted first store
        send_item(spa_pkg::KIND_LOAD_FIRST, 32'd1, 16'd10);
        send_item(spa_pkg::KIND_LOAD_FIRST, 32'd2, 16'd300);
        send_item(spa_pkg::KIND_LOAD_SECOND, 32'd3, 16'd200);
        send_run();
        // Only one store filled, each in turn
        send_item(spa_pkg::KIND_LOAD_SECOND, 32'h5555_aaaa, 16'h5aa5);
        send_run();
        send_item(spa_pkg::KIND_LOAD_FIRST, 32'haaaa_5555, 16'ha55a);
        send_run();

        // Pressure: hold the sink off while both stores overfill and a run
        // starts, so the block backs up and drops s_ready for a long stretch
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off <= 1'b0;
            end
        join_none
        send_term_set(spa_pkg::MAX_TERMS_DEF + 2, 1'b1, 1'b1);
        send_run();
        send_term_set(3, 1'b1, 1'b0);
        send_run();

        // Random phases, each with its own idle and stall rates
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_send[p];
            stall_pct    <= phase_stall[p];
            target        = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
                random_action();
        end
        // Close off any partial load so it is merged and checked too
        send_run();
        s_valid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
